@@ design/bdq_pkg.sv @@
// Shared constants, codes and address helpers for the bounded deque with search.
// Depends on nothing; the deque top imports it, while bdq_ram needs no package.
package bdq_pkg;

	localparam int DEPTH = 64;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int MODE_W     = 4;
	localparam int DATA_W     = 32;
	localparam int ITEM_IDX_W = 6;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;

	// Width that holds both an item index and an entry count for range checks.
	localparam int CMP_W = (CNT_W > ITEM_IDX_W) ? CNT_W : ITEM_IDX_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	localparam logic [MODE_W-1:0] MODE_APPEND     = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PREPEND    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_FIND_FIRST = 4'd4;
	localparam logic [MODE_W-1:0] MODE_FIND_LAST  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_READ       = 4'd6;
	localparam logic [MODE_W-1:0] MODE_WRITE      = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd8;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Maps a logical position to a physical slot of the circular store.
	function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
			input logic [IDX_W-1:0] pos);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, pos};
		if (sum >= (IDX_W + 1)'(DEPTH)) begin
			sum = sum - (IDX_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

@@ design/bdq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package needed.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/bounded_deque_with_search_unit.sv @@
// Bounded deque of signed 32-bit words with forward and backward linear search.
// Append, prepend, pops, write, clear, unused-mode and out-of-range or empty requests: result in
// the cycle after acceptance. Read: via S_READ, which registers the RAM data. Search: one stored
// entry compared per cycle through the registered read port of the entry RAM. busy is high while a
// read or search runs. Results are strobed by done for one cycle and cannot be stalled.
// Reset (arst_n low) empties the store at once; entry contents stay undefined until written.
module bounded_deque_with_search_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [bdq_pkg::MODE_W-1:0]         mode,
	input  logic signed [bdq_pkg::DATA_W-1:0]  data_value,
	input  logic [bdq_pkg::ITEM_IDX_W-1:0]     item_index,
	output logic                               done,
	output logic [bdq_pkg::STATUS_W-1:0]       status,
	output logic                               found,
	output logic [bdq_pkg::ITEM_IDX_W-1:0]     found_index,
	output logic signed [bdq_pkg::DATA_W-1:0]  read_value,
	output logic [bdq_pkg::COUNT_W-1:0]        count_now
);

	import bdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         pos_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     dir_q;
	logic [DATA_W-1:0]        key_q;
	logic                     v_s1;
	logic [IDX_W-1:0]         pos_s1;

	logic                     done_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     found_q;
	logic [ITEM_IDX_W-1:0]    found_index_q;
	logic [DATA_W-1:0]        read_value_q;
	logic [COUNT_W-1:0]       count_now_q;

	logic                     accept;
	logic                     in_range;
	logic                     is_full;
	logic                     is_empty;
	logic [IDX_W-1:0]         lg_idx;
	logic [IDX_W-1:0]         head_dec;
	logic [IDX_W-1:0]         head_inc;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [IDX_W-1:0]         ram_raddr;
	logic [DATA_W-1:0]        rd_data;
	logic                     hit;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign in_range = CMP_W'(item_index) < CMP_W'(count_q);
	assign is_full  = (count_q == CNT_FULL);
	assign is_empty = (count_q == '0);
	assign lg_idx   = IDX_W'(item_index);
	assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign hit      = v_s1 && (rd_data == key_q);

	assign ram_raddr = phys_addr(head_q, (state_q == S_SCAN) ? pos_q : lg_idx);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys_addr(head_q, lg_idx);
		if (accept) begin
			case (mode)
				MODE_APPEND: begin
					ram_we    = !is_full;
					ram_waddr = phys_addr(head_q, IDX_W'(count_q));
				end
				MODE_PREPEND: begin
					ram_we    = !is_full;
					ram_waddr = head_dec;
				end
				MODE_WRITE: begin
					ram_we = in_range;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	bdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(data_value),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			head_q        <= '0;
			pos_q         <= '0;
			rem_q         <= '0;
			dir_q         <= 1'b0;
			key_q         <= '0;
			v_s1          <= 1'b0;
			pos_s1        <= '0;
			done_q        <= 1'b0;
			status_q      <= ST_OK;
			found_q       <= 1'b0;
			found_index_q <= '0;
			read_value_q  <= '0;
			count_now_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					v_s1 <= 1'b0;
					if (accept) begin
						status_q      <= ST_OK;
						found_q       <= 1'b0;
						found_index_q <= '0;
						read_value_q  <= '0;
						count_now_q   <= COUNT_W'(count_q);
						done_q        <= 1'b1;
						case (mode)
							MODE_APPEND, MODE_PREPEND: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									count_q     <= count_q + 1'b1;
									count_now_q <= COUNT_W'(count_q + 1'b1);
									if (mode == MODE_PREPEND) begin
										head_q <= head_dec;
									end
								end
							end
							MODE_POP_BACK, MODE_POP_FRONT: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q     <= count_q - 1'b1;
									count_now_q <= COUNT_W'(count_q - 1'b1);
									if (mode == MODE_POP_FRONT) begin
										head_q <= head_inc;
									end
								end
							end
							MODE_FIND_FIRST, MODE_FIND_LAST: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									// The result is reported when the scan ends.
									done_q  <= 1'b0;
									state_q <= S_SCAN;
									key_q   <= data_value;
									rem_q   <= count_q;
									dir_q   <= (mode == MODE_FIND_LAST);
									pos_q   <= (mode == MODE_FIND_LAST) ?
										IDX_W'(count_q - 1'b1) : '0;
								end
							end
							MODE_READ: begin
								if (in_range) begin
									done_q  <= 1'b0;
									state_q <= S_READ;
								end else begin
									status_q <= ST_RANGE;
								end
							end
							MODE_WRITE: begin
								if (!in_range) begin
									status_q <= ST_RANGE;
								end
							end
							MODE_CLEAR: begin
								count_q     <= '0;
								count_now_q <= '0;
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_READ: begin
					read_value_q <= rd_data;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_SCAN: begin
					// Addresses go out one per cycle; each compare sees the data in the following cycle.
					if (rem_q != '0) begin
						pos_q  <= dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
						rem_q  <= rem_q - 1'b1;
						v_s1   <= 1'b1;
						pos_s1 <= pos_q;
					end else begin
						v_s1 <= 1'b0;
					end
					if (hit) begin
						found_q       <= 1'b1;
						found_index_q <= ITEM_IDX_W'(pos_s1);
						done_q        <= 1'b1;
						v_s1          <= 1'b0;
						state_q       <= S_IDLE;
					end else if (v_s1 && rem_q == '0) begin
						done_q  <= 1'b1;
						v_s1    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign found_index = found_index_q;
	assign read_value  = read_value_q;
	assign count_now   = count_now_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count exceeds capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobed while a request is still running");

	a_compare_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q == S_SCAN)
		else $error("search compare pending outside a scan");

	a_scan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> rem_q <= count_q)
		else $error("scan covers more entries than are stored");

	a_count_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(accept))
		else $error("entry count changed without a request");
`endif

endmodule

@@ dv/tb_bounded_deque_with_search_unit.sv @@
// Self-checking testbench for bounded_deque_with_search_unit: directed and random deque requests,
// each result checked against a predictor of the store kept inside this file.
// Depends on bdq_pkg and the design top; needs no files or arguments at run time.
module tb_bounded_deque_with_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int          QUIET_LIMIT = 3000;
	localparam int          TAIL_CYCLES = DEPTH + 16;
	localparam logic [MODE_W-1:0] MODE_SPARE = MODE_CLEAR + 1'b1;
	localparam logic [MODE_W-1:0] MODE_TOP   = '1;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

	typedef struct {
		logic [MODE_W-1:0]         mode;
		logic signed [DATA_W-1:0]  data;
		logic [ITEM_IDX_W-1:0]     index;
		int unsigned               idle_pct;
		bit                        drain;
	} deque_req_t;

	typedef struct {
		status_t                   status;
		logic                      found;
		logic [ITEM_IDX_W-1:0]     found_index;
		logic signed [DATA_W-1:0]  read_value;
		logic [COUNT_W-1:0]        count_now;
	} outcome_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [MODE_W-1:0] mode = MODE_APPEND;
	logic signed [DATA_W-1:0] data_value = '0;
	logic [ITEM_IDX_W-1:0] item_index = '0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic found;
	logic [ITEM_IDX_W-1:0] found_index;
	logic signed [DATA_W-1:0] read_value;
	logic [COUNT_W-1:0] count_now;

	bounded_deque_with_search_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.data_value(data_value),
		.item_index(item_index),
		.done(done),
		.status(status),
		.found(found),
		.found_index(found_index),
		.read_value(read_value),
		.count_now(count_now)
	);

	// Shadow copy of the deque contents, updated as each request is accepted.
	logic signed [DATA_W-1:0] words [DEPTH];
	int words_len = 0;

	deque_req_t req_backlog[$];
	outcome_t pending_results[$];
	deque_req_t in_flight;
	int unsigned issued = 0;
	int unsigned seen = 0;
	int unsigned errors = 0;
	int unsigned quiet = 0;
	int unsigned status_tally [4] = '{0, 0, 0, 0};
	int unsigned search_hits = 0;

	// Stimulus generation state.
	int unsigned gen_idle = 0;
	int gen_len = 0;
	logic signed [DATA_W-1:0] value_pool [4];

	function automatic outcome_t deque_apply(input deque_req_t r);
		outcome_t o;
		int i;
		int hit;
		o.status = ST_OK;
		o.found = 1'b0;
		o.found_index = '0;
		o.read_value = '0;
		hit = -1;
		case (r.mode)
			MODE_APPEND: begin
				if (words_len >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					words[words_len] = r.data;
					words_len++;
				end
			end
			MODE_PREPEND: begin
				if (words_len >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					for (i = words_len; i > 0; i--) words[i] = words[i-1];
					words[0] = r.data;
					words_len++;
				end
			end
			MODE_POP_BACK: begin
				if (words_len == 0) o.status = ST_EMPTY;
				else words_len--;
			end
			MODE_POP_FRONT: begin
				if (words_len == 0) begin
					o.status = ST_EMPTY;
				end else begin
					for (i = 0; i + 1 < words_len; i++) words[i] = words[i+1];
					words_len--;
				end
			end
			MODE_FIND_FIRST: begin
				if (words_len == 0) begin
					o.status = ST_EMPTY;
				end else begin
					for (i = 0; i < words_len; i++) begin
						if (hit < 0 && words[i] == r.data) hit = i;
					end
				end
			end
			MODE_FIND_LAST: begin
				if (words_len == 0) begin
					o.status = ST_EMPTY;
				end else begin
					for (i = words_len - 1; i >= 0; i--) begin
						if (hit < 0 && words[i] == r.data) hit = i;
					end
				end
			end
			MODE_READ: begin
				if (int'(r.index) >= words_len) o.status = ST_RANGE;
				else o.read_value = words[r.index];
			end
			MODE_WRITE: begin
				if (int'(r.index) >= words_len) o.status = ST_RANGE;
				else words[r.index] = r.data;
			end
			MODE_CLEAR: words_len = 0;
			default: ;
		endcase
		if (hit >= 0) begin
			o.found = 1'b1;
			o.found_index = ITEM_IDX_W'(hit);
		end
		o.count_now = COUNT_W'(words_len);
		return o;
	endfunction

	task automatic queue_op(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] d,
			input logic [ITEM_IDX_W-1:0] ix);
		deque_req_t r;
		r.mode = m;
		r.data = d;
		r.index = ix;
		r.idle_pct = gen_idle;
		r.drain = 1'b0;
		req_backlog.push_back(r);
		// Rough length tracking, only used to aim indexes near the live range.
		case (m)
			MODE_APPEND, MODE_PREPEND: if (gen_len < DEPTH) gen_len++;
			MODE_POP_BACK, MODE_POP_FRONT: if (gen_len > 0) gen_len--;
			MODE_CLEAR: gen_len = 0;
			default: ;
		endcase
	endtask

	// The sender holds off at this marker until every outstanding request has its result.
	task automatic queue_pause();
		deque_req_t r;
		r.mode = MODE_APPEND;
		r.data = '0;
		r.index = '0;
		r.idle_pct = 0;
		r.drain = 1'b1;
		req_backlog.push_back(r);
	endtask

	// Values are mostly drawn from a small pool so that searches find matches and duplicates.
	function automatic logic signed [DATA_W-1:0] likely_value();
		if ($urandom_range(3) != 0) return value_pool[$urandom_range(3)];
		return $urandom;
	endfunction

	function automatic logic [ITEM_IDX_W-1:0] likely_index();
		if (gen_len > 0 && $urandom_range(9) < 7) return ITEM_IDX_W'($urandom_range(gen_len));
		return ITEM_IDX_W'($urandom_range(63));
	endfunction

	task automatic queue_random_op();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 20) queue_op(MODE_APPEND, likely_value(), likely_index());
		else if (pick < 32) queue_op(MODE_PREPEND, likely_value(), likely_index());
		else if (pick < 40) queue_op(MODE_POP_BACK, likely_value(), likely_index());
		else if (pick < 48) queue_op(MODE_POP_FRONT, likely_value(), likely_index());
		else if (pick < 60) queue_op(MODE_FIND_FIRST, likely_value(), likely_index());
		else if (pick < 72) queue_op(MODE_FIND_LAST, likely_value(), likely_index());
		else if (pick < 84) queue_op(MODE_READ, likely_value(), likely_index());
		else if (pick < 94) queue_op(MODE_WRITE, likely_value(), likely_index());
		else if (pick < 96) queue_op(MODE_CLEAR, likely_value(), likely_index());
		else queue_op(MODE_TOP - MODE_W'($urandom_range(6)), $urandom, likely_index());
	endtask

	// Fill to capacity, push against the full store, scan it end to end, touch the last slot, then clear or pop.
	task automatic queue_fill();
		while (gen_len < DEPTH) begin
			queue_op($urandom_range(1) ? MODE_APPEND : MODE_PREPEND, likely_value(), '0);
		end
		queue_op(MODE_APPEND, likely_value(), '0);
		queue_op(MODE_PREPEND, likely_value(), '0);
		queue_op(MODE_FIND_FIRST, likely_value(), '0);
		queue_op(MODE_FIND_LAST, likely_value(), '0);
		queue_op(MODE_FIND_LAST, $urandom, '0);
		queue_op(MODE_READ, '0, ITEM_IDX_W'(DEPTH - 1));
		queue_op(MODE_WRITE, $urandom, ITEM_IDX_W'(DEPTH - 1));
		if ($urandom_range(1)) begin
			queue_op(MODE_CLEAR, '0, '0);
		end else begin
			repeat (3) queue_op(MODE_POP_FRONT, '0, '0);
		end
	endtask

	task automatic random_phase(input int unsigned pct, input int unsigned quota);
		int unsigned fill_at;
		int unsigned pick;
		bit filled;
		int k;
		gen_idle = pct;
		filled = 1'b0;
		fill_at = req_backlog.size() + $urandom_range(quota / 2);
		quota = quota + req_backlog.size();
		for (k = 0; k < 4; k++) value_pool[k] = $urandom;
		while (req_backlog.size() < quota) begin
			pick = $urandom_range(99);
			if ((!filled && req_backlog.size() >= fill_at) || pick < 2) begin
				queue_fill();
				filled = 1'b1;
			end else if (pick < 5) begin
				queue_pause();
			end else if (pick < 10) begin
				queue_op(MODE_W'($urandom_range(15)), $urandom, ITEM_IDX_W'($urandom_range(63)));
			end else begin
				repeat (6) queue_random_op();
				value_pool[$urandom_range(3)] = $urandom;
			end
		end
		queue_pause();
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Driver: a request stays on the ports until the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic took;
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_APPEND;
			data_value <= '0;
			item_index <= '0;
		end else begin
			took = start && !busy;
			if (took) begin
				pending_results.push_back(deque_apply(in_flight));
				issued <= issued + 1;
			end
			if (!start || took) begin
				if (req_backlog.size() > 0 && req_backlog[0].drain && !took && !done
						&& issued == seen) begin
					void'(req_backlog.pop_front());
				end
				if (req_backlog.size() > 0 && !req_backlog[0].drain
						&& $urandom_range(99) >= req_backlog[0].idle_pct) begin
					in_flight = req_backlog.pop_front();
					start <= 1'b1;
					mode <= in_flight.mode;
					data_value <= in_flight.data;
					item_index <= in_flight.index;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: issued counts only requests accepted before this edge, so a result that
	// could not yet have been caused is reported rather than matched.
	always @(posedge clk) begin : check_proc
		outcome_t want;
		if (arst_n && done) begin
			if (seen >= issued || pending_results.size() == 0) begin
				$error("unexpected result: status %0d count_now %0d", status, count_now);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					errors++;
				end
				if (found_index !== want.found_index) begin
					$error("found_index: expected %0d, got %0d", want.found_index, found_index);
					errors++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, read_value);
					errors++;
				end
				if (count_now !== want.count_now) begin
					$error("count_now: expected %0d, got %0d", want.count_now, count_now);
					errors++;
				end
				status_tally[int'(want.status)]++;
				if (want.found) search_hits++;
				seen <= seen + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("tb_bounded_deque_with_search_unit: done, errors");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		// Directed requests: empty store, extreme values, duplicates for both search
		// directions, range limits and unused modes.
		gen_idle = 9;
		queue_op(MODE_POP_BACK, '0, '0);
		queue_op(MODE_POP_FRONT, '0, '0);
		queue_op(MODE_FIND_FIRST, '0, '0);
		queue_op(MODE_FIND_LAST, -1, '0);
		queue_op(MODE_READ, '0, '0);
		queue_op(MODE_WRITE, -1, '1);
		queue_op(MODE_TOP, -1, '1);
		queue_op(MODE_APPEND, WORD_MAX, '0);
		queue_op(MODE_PREPEND, WORD_MIN, '0);
		queue_op(MODE_APPEND, -1, '0);
		queue_op(MODE_APPEND, WORD_MAX, '0);
		queue_op(MODE_FIND_FIRST, WORD_MAX, '0);
		queue_op(MODE_FIND_LAST, WORD_MAX, '0);
		queue_op(MODE_FIND_LAST, WORD_MIN, '0);
		queue_op(MODE_FIND_FIRST, '0, '0);
		queue_op(MODE_WRITE, '0, ITEM_IDX_W'(2));
		queue_op(MODE_READ, '0, '0);
		queue_op(MODE_READ, '0, ITEM_IDX_W'(3));
		queue_op(MODE_READ, '0, ITEM_IDX_W'(4));
		queue_op(MODE_WRITE, WORD_MAX, '1);
		queue_op(MODE_POP_FRONT, '0, '0);
		queue_op(MODE_POP_BACK, '0, '0);
		queue_op(MODE_READ, '0, ITEM_IDX_W'(1));
		queue_op(MODE_CLEAR, '0, '0);
		queue_op(MODE_SPARE, WORD_MIN, ITEM_IDX_W'(21));
		queue_pause();

		random_phase(9, 160);
		random_phase(85, 160);
		random_phase(0, 160);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || start || seen != issued) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d ok, %0d full, %0d empty, %0d out of range.",
			issued, status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
		$display("Searches that found a match: %0d; mismatches reported: %0d.",
			search_hits, errors);
		if (errors == 0) begin
			$display("tb_bounded_deque_with_search_unit: done, clean");
		end else begin
			$display("tb_bounded_deque_with_search_unit: done, errors");
		end
		$finish;
	end

endmodule
